>>> sv/sorted_occurrence_counter_core_defines.svh
`ifndef SORTED_OCCURRENCE_COUNTER_CORE_DEFINES_SVH
`define SORTED_OCCURRENCE_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SOC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/soc_pkg.sv
package soc_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;
    localparam int COUNT_W = 11;

    // request action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } soc_req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] last_index;
        logic [COUNT_W-1:0] occurrence_count;
    } soc_rsp_t;

endpackage

>>> sv/soc_ifaces.sv
interface soc_req_if;
    logic              valid;
    logic              ready;
    soc_pkg::soc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface soc_rsp_if;
    logic              valid;
    logic              ready;
    soc_pkg::soc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/soc_ram.sv
module soc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sorted_occurrence_counter_core.sv
// load request: written straight into the entry ram when taken, dropped if its index is beyond the ram depth
// query request: binary search for the first match, then a second pass for the last match, p probes per pass
//   each probe runs ST_ADDR then ST_CMP, p at most floor(log2(len)) + 1, a miss skips the second pass
// one query at a time; requests are taken only in ST_IDLE, which is entered again when the result is published
//   a finished result waits in ST_FIN, the sequencer stalls until the output register is free or draining
// reset: async active low, clears control state and array_length; entry ram is not cleared
`include "sorted_occurrence_counter_core_defines.svh"
module sorted_occurrence_counter_core #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [soc_pkg::LEN_W-1:0]  cfg_wr_data,
    soc_req_if.sink                    request,
    soc_rsp_if.source                  result
);

    // ram address width and signed position width (holds -1 up to DEPTH)
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1) + 1;
    localparam logic [31:0] DEPTH_U = 32'(DEPTH);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [soc_pkg::LEN_W-1:0]     array_length_reg, array_length_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          last_pass_reg, last_pass_next;

    logic signed [PW-1:0]          lo_reg, lo_next;
    logic signed [PW-1:0]          hi_reg, hi_next;
    logic signed [PW-1:0]          hit_reg, hit_next;
    logic signed [PW-1:0]          mid_reg, mid_next;
    logic signed [PW-1:0]          first_reg, first_next;
    logic signed [PW-1:0]          len_reg, len_next;
    logic [VALUE_WIDTH-1:0]        key_reg, key_next;
    soc_pkg::soc_rsp_t             res_reg, res_next;
    soc_pkg::soc_rsp_t             out_reg, out_next;

    // search datapath
    logic signed [PW-1:0]          mid_c;
    logic [31:0]                   alen_ext;
    logic signed [PW-1:0]          len_c;
    logic [VALUE_WIDTH-1:0]        value_fit;

    // entry ram ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [VALUE_WIDTH-1:0]        ram_rdata;

    logic                          req_fire;
    logic                          load_ok;

    // incoming value taken as a VALUE_WIDTH bit word
    if (VALUE_WIDTH <= soc_pkg::VALUE_W)
    begin : g_value_trunc
        assign value_fit = request.data.value[VALUE_WIDTH-1:0];
    end
    else
    begin : g_value_ext
        assign value_fit = {{(VALUE_WIDTH - soc_pkg::VALUE_W){1'b0}}, request.data.value};
    end

    // searched length is clamped to the ram depth
    assign alen_ext = 32'(array_length_reg);
    assign len_c    = PW'((alen_ext > DEPTH_U) ? DEPTH_U : alen_ext);

    // floor midpoint, lo <= hi whenever it is used
    assign mid_c = lo_reg + ((hi_reg - lo_reg) >>> 1);

    assign request.ready = (state_reg == ST_IDLE);
    assign req_fire      = request.valid && request.ready;

    // loads beyond the ram depth are dropped
    assign load_ok   = (32'(request.data.index) < DEPTH_U);
    assign ram_we    = req_fire && (request.data.action == soc_pkg::ACT_LOAD) && load_ok;
    assign ram_waddr = AW'(request.data.index);
    assign ram_re    = (state_reg == ST_ADDR) && (lo_reg <= hi_reg);
    assign ram_raddr = AW'($unsigned(mid_c));

    soc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_fit),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic signed [PW-1:0] last_pos;
        logic signed [PW:0]   span;

        state_next        = state_reg;
        array_length_next = array_length_reg;
        out_valid_next    = out_valid_reg;
        last_pass_next    = last_pass_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        hit_next          = hit_reg;
        mid_next          = mid_reg;
        first_next        = first_reg;
        len_next          = len_reg;
        key_next          = key_reg;
        res_next          = res_reg;
        out_next          = out_reg;
        last_pos          = '0;
        span              = '0;

        if (cfg_wr_en)
        begin
            array_length_next = cfg_wr_data;
        end

        // result register drains independently of the sequencer
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (request.data.action == soc_pkg::ACT_QUERY))
                begin
                    key_next       = value_fit;
                    len_next       = len_c;
                    lo_next        = '0;
                    hi_next        = len_c - PW'(1);
                    hit_next       = -PW'(1);
                    last_pass_next = 1'b0;
                    state_next     = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (lo_reg <= hi_reg)
                begin
                    // probe issued to the ram this cycle
                    mid_next   = mid_c;
                    state_next = ST_CMP;
                end
                else if (!last_pass_reg)
                begin
                    if (hit_reg < 0)
                    begin
                        // no match at all
                        res_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // first match known, rerun for the last one
                        first_next     = hit_reg;
                        last_pass_next = 1'b1;
                        lo_next        = '0;
                        hi_next        = len_reg - PW'(1);
                        hit_next       = -PW'(1);
                    end
                end
                else
                begin
                    // unsorted store can hide every match from the last pass
                    last_pos = (hit_reg < 0) ? first_reg : hit_reg;
                    span     = (PW + 1)'(last_pos) - (PW + 1)'(first_reg) + (PW + 1)'(1);
                    res_next.found            = 1'b1;
                    res_next.first_index      = soc_pkg::INDEX_W'($unsigned(first_reg));
                    res_next.last_index       = soc_pkg::INDEX_W'($unsigned(last_pos));
                    res_next.occurrence_count = (last_pos >= first_reg) ?
                        soc_pkg::COUNT_W'($unsigned(span)) : '0;
                    state_next = ST_FIN;
                end
            end
            ST_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    hit_next = mid_reg;
                    if (last_pass_reg)
                    begin
                        lo_next = mid_reg + PW'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg - PW'(1);
                    end
                end
                else if ($signed(ram_rdata) > $signed(key_reg))
                begin
                    hi_next = mid_reg - PW'(1);
                end
                else
                begin
                    lo_next = mid_reg + PW'(1);
                end
                state_next = ST_ADDR;
            end
            ST_FIN:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            array_length_reg <= '0;
            out_valid_reg    <= 1'b0;
            last_pass_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            array_length_reg <= array_length_next;
            out_valid_reg    <= out_valid_next;
            last_pass_reg    <= last_pass_next;
        end
    end

    // search datapath and payload, no reset
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        hit_reg   <= hit_next;
        mid_reg   <= mid_next;
        first_reg <= first_next;
        len_reg   <= len_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // probe address stays inside the live window and the searched length
    `SOC_ASSERT_NOW(a_probe_in_window, clk, rst_n, (state_reg == ST_CMP), ((mid_reg >= lo_reg) && (mid_reg <= hi_reg) && (mid_reg < len_reg)), "probe outside search window")
    // last pass only runs after a first match
    `SOC_ASSERT_NOW(a_last_after_first, clk, rst_n, last_pass_reg && (state_reg != ST_IDLE), (first_reg >= 0), "last pass without first match")
    // a finished query is published the cycle after the output frees up
    `SOC_ASSERT_NEXT(a_fin_publishes, clk, rst_n, (state_reg == ST_FIN) && (!out_valid_reg || result.ready), (out_valid_reg && (state_reg == ST_IDLE)), "result not published")
    // a miss never reports a count
    `SOC_ASSERT_NOW(a_miss_no_count, clk, rst_n, out_valid_reg, (out_reg.found || (out_reg.occurrence_count == '0)), "count on a miss")

endmodule
